FILE: rtl/ppr_pkg.sv
// Shared types, widths and constants of the periodic point rotator.
`default_nettype none

package ppr_pkg;

    // Field widths fixed by the interface.
    localparam int COORD_BITS   = 16;
    localparam int FRAME_BITS   = 32;
    localparam int PERIOD_BITS  = 16;
    localparam int DEF_ANGLE_BITS = 16;
    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 16'd60;

    // Queue between the angle front end and the rotation back end.
    localparam int QUEUE_DEPTH  = 4;

    // CORDIC datapath: x and y scaled by 2^30, z in 2^32 units per turn.
    localparam int CORDIC_STEPS = 16;
    localparam int XW           = 34;
    localparam int ZW           = 33;
    localparam int TRIG_W       = 18;
    localparam logic signed [XW-1:0] CORDIC_K = 34'sd652032874;

    // Input request.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_re;
        logic signed [COORD_BITS-1:0] point_im;
        logic [FRAME_BITS-1:0]        frame_count;
        logic                         last_point;
    } t_in_req;

    // Output request.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] rotated_re;
        logic signed [COORD_BITS-1:0] rotated_im;
        logic                         last_out;
    } t_out_res;

    // Point carried alongside the angle through the pipeline.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] re;
        logic signed [COORD_BITS-1:0] im;
        logic                         last;
    } t_point;

    // Arctangent of 2^-i in 2^32 units per full turn.
    function automatic logic signed [ZW-1:0] atan_turn(input logic [3:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            4'd0:    v = 33'sd536870912;
            4'd1:    v = 33'sd316933406;
            4'd2:    v = 33'sd167458907;
            4'd3:    v = 33'sd85004756;
            4'd4:    v = 33'sd42667331;
            4'd5:    v = 33'sd21354465;
            4'd6:    v = 33'sd10679838;
            4'd7:    v = 33'sd5340245;
            4'd8:    v = 33'sd2670163;
            4'd9:    v = 33'sd1335087;
            4'd10:   v = 33'sd667544;
            4'd11:   v = 33'sd333772;
            4'd12:   v = 33'sd166886;
            4'd13:   v = 33'sd83443;
            4'd14:   v = 33'sd41722;
            4'd15:   v = 33'sd20861;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/ppr_front.sv
// Front end: pipelined restoring division giving the quantised rotation angle.
`default_nettype none

module ppr_front #(
    parameter int ANGLE_BITS = ppr_pkg::DEF_ANGLE_BITS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire ppr_pkg::t_in_req                i_req,
    input  wire logic [ppr_pkg::PERIOD_BITS-1:0] i_period,
    output logic                                 o_valid,
    input  wire logic                            i_full,
    output logic [ANGLE_BITS-1:0]                o_angle,
    output ppr_pkg::t_point                      o_point
);
    import ppr_pkg::*;

    // First FRAME_BITS stages form frame mod period, the rest the angle quotient.
    localparam int NS = FRAME_BITS + ANGLE_BITS;

    logic                   r_v   [0:NS];
    logic [PERIOD_BITS-1:0] r_rem [0:NS];
    logic [FRAME_BITS-1:0]  r_frm [0:NS];
    logic [ANGLE_BITS-1:0]  r_q   [0:NS];
    t_point                 r_pt  [0:NS];

    logic [PERIOD_BITS-1:0] n_rem [1:NS];
    logic [FRAME_BITS-1:0]  n_frm [1:NS];
    logic [ANGLE_BITS-1:0]  n_q   [1:NS];

    logic [PERIOD_BITS-1:0] per_eff;
    logic                   en;

    // The pipeline moves whenever its last stage can leave for the queue.
    assign en      = !r_v[NS] || !i_full;
    assign o_stall = !en;
    assign per_eff = (i_period == '0) ? PERIOD_BITS'(1) : i_period;

    // One restoring step per stage; the frame word feeds bits, then zeros.
    always_comb begin
        logic [PERIOD_BITS:0] t;
        logic                 ge;
        for (int k = 0; k < NS; k++) begin
            t  = {r_rem[k], r_frm[k][FRAME_BITS-1]};
            ge = (t >= {1'b0, per_eff});
            n_rem[k+1] = ge ? PERIOD_BITS'(t - {1'b0, per_eff}) : t[PERIOD_BITS-1:0];
            n_frm[k+1] = {r_frm[k][FRAME_BITS-2:0], 1'b0};
            n_q[k+1]   = {r_q[k][ANGLE_BITS-2:0], ge};
        end
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NS; k++) r_v[k] <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_valid;
            for (int k = 0; k < NS; k++) r_v[k+1] <= r_v[k];
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rem[0] <= '0;
            r_frm[0] <= i_req.frame_count;
            r_q[0]   <= '0;
            r_pt[0]  <= '{re: i_req.point_re, im: i_req.point_im, last: i_req.last_point};
            for (int k = 0; k < NS; k++) begin
                r_rem[k+1] <= n_rem[k+1];
                r_frm[k+1] <= n_frm[k+1];
                r_q[k+1]   <= n_q[k+1];
                r_pt[k+1]  <= r_pt[k];
            end
        end
    end

    assign o_valid = r_v[NS];
    assign o_angle = r_q[NS];
    assign o_point = r_pt[NS];

endmodule

`default_nettype wire

FILE: rtl/ppr_queue.sv
// Short first-in first-out queue between front end and back end.
`default_nettype none

module ppr_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    output logic                  o_valid,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data
);
    import ppr_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [0:QUEUE_DEPTH-1];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;
    logic             push, pop;

    assign o_full  = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign push    = i_push && !o_full;
    assign pop     = i_pop && o_valid;
    assign o_data  = r_mem[r_rp];

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= PW'(r_wp + 1'b1);
            if (pop)  r_rp <= PW'(r_rp + 1'b1);
            r_cnt <= CW'(r_cnt + CW'(push) - CW'(pop));
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ppr_back.sv
// Back end: CORDIC sine and cosine, complex multiply, rounding and saturation.
`default_nettype none

module ppr_back #(
    parameter int ANGLE_BITS = ppr_pkg::DEF_ANGLE_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_pop,
    input  wire logic [ANGLE_BITS-1:0] i_angle,
    input  wire ppr_pkg::t_point       i_point,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output ppr_pkg::t_out_res          o_res
);
    import ppr_pkg::*;

    localparam int S  = CORDIC_STEPS;
    localparam int PW = COORD_BITS + TRIG_W;
    localparam int SW = PW + 1;
    localparam logic signed [SW-1:0] C_MAX = SW'((2 ** (COORD_BITS - 1)) - 1);
    localparam logic signed [SW-1:0] C_MIN = -C_MAX - SW'(1);
    localparam logic signed [SW-1:0] RND   = SW'(8192);
    localparam logic signed [XW-1:0] TRND  = XW'(32768);

    // CORDIC stage registers.
    logic                    r_cv   [0:S];
    logic signed [XW-1:0]    r_x    [0:S];
    logic signed [XW-1:0]    r_y    [0:S];
    logic signed [ZW-1:0]    r_z    [0:S];
    logic [1:0]              r_quad [0:S];
    t_point                  r_pt   [0:S];

    logic signed [XW-1:0]    n_x    [1:S];
    logic signed [XW-1:0]    n_y    [1:S];
    logic signed [ZW-1:0]    n_z    [1:S];

    // Trig, product and output registers.
    logic                    r_tv, r_mv, r_ov;
    logic signed [TRIG_W-1:0] r_c, r_s;
    t_point                  r_tpt;
    logic signed [PW-1:0]    r_xc, r_ys, r_xs, r_yc;
    logic                    r_ml;
    t_out_res                r_res;

    logic signed [TRIG_W-1:0] n_c, n_s, cr, sr;
    logic signed [PW-1:0]    n_xc, n_ys, n_xs, n_yc;
    logic signed [SW-1:0]    sum_re, sum_im, sh_re, sh_im;
    logic signed [COORD_BITS-1:0] n_re, n_im;
    logic signed [ZW-1:0]    z0;
    logic                    en;

    assign en    = !r_ov || !i_stall;
    assign o_pop = en && i_valid;
    assign z0    = $signed(ZW'(i_angle[ANGLE_BITS-3:0]) << (32 - ANGLE_BITS));

    // Rotation steps, one per stage.
    always_comb begin
        for (int i = 0; i < S; i++) begin
            if (!r_z[i][ZW-1]) begin
                n_x[i+1] = r_x[i] - (r_y[i] >>> i);
                n_y[i+1] = r_y[i] + (r_x[i] >>> i);
                n_z[i+1] = r_z[i] - atan_turn(4'(i));
            end else begin
                n_x[i+1] = r_x[i] + (r_y[i] >>> i);
                n_y[i+1] = r_y[i] - (r_x[i] >>> i);
                n_z[i+1] = r_z[i] + atan_turn(4'(i));
            end
        end
    end

    // Round to Q1.14 and fold the quadrant back in.
    always_comb begin
        cr = TRIG_W'((r_x[S] + TRND) >>> 16);
        sr = TRIG_W'((r_y[S] + TRND) >>> 16);
        case (r_quad[S])
            2'd0:    begin n_c = cr;  n_s = sr;  end
            2'd1:    begin n_c = -sr; n_s = cr;  end
            2'd2:    begin n_c = -cr; n_s = -sr; end
            default: begin n_c = sr;  n_s = -cr; end
        endcase
    end

    // Four products of the complex multiply.
    always_comb begin
        n_xc = r_tpt.re * r_c;
        n_ys = r_tpt.im * r_s;
        n_xs = r_tpt.re * r_s;
        n_yc = r_tpt.im * r_c;
    end

    // Sum, round half up and clamp to the coordinate range.
    always_comb begin
        sum_re = SW'(r_xc) - SW'(r_ys) + RND;
        sum_im = SW'(r_xs) + SW'(r_yc) + RND;
        sh_re  = sum_re >>> 14;
        sh_im  = sum_im >>> 14;
        if (sh_re > C_MAX)      n_re = C_MAX[COORD_BITS-1:0];
        else if (sh_re < C_MIN) n_re = C_MIN[COORD_BITS-1:0];
        else                    n_re = sh_re[COORD_BITS-1:0];
        if (sh_im > C_MAX)      n_im = C_MAX[COORD_BITS-1:0];
        else if (sh_im < C_MIN) n_im = C_MIN[COORD_BITS-1:0];
        else                    n_im = sh_im[COORD_BITS-1:0];
    end

    // Valid bits of every stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= S; i++) r_cv[i] <= 1'b0;
            r_tv <= 1'b0;
            r_mv <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_cv[0] <= i_valid;
            for (int i = 0; i < S; i++) r_cv[i+1] <= r_cv[i];
            r_tv <= r_cv[S];
            r_mv <= r_tv;
            r_ov <= r_mv;
        end
    end

    // Payload of every stage.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x[0]    <= CORDIC_K;
            r_y[0]    <= '0;
            r_z[0]    <= z0;
            r_quad[0] <= i_angle[ANGLE_BITS-1:ANGLE_BITS-2];
            r_pt[0]   <= i_point;
            for (int i = 0; i < S; i++) begin
                r_x[i+1]    <= n_x[i+1];
                r_y[i+1]    <= n_y[i+1];
                r_z[i+1]    <= n_z[i+1];
                r_quad[i+1] <= r_quad[i];
                r_pt[i+1]   <= r_pt[i];
            end
            r_c   <= n_c;
            r_s   <= n_s;
            r_tpt <= r_pt[S];
            r_xc  <= n_xc;
            r_ys  <= n_ys;
            r_xs  <= n_xs;
            r_yc  <= n_yc;
            r_ml  <= r_tpt.last;
            r_res <= '{rotated_re: n_re, rotated_im: n_im, last_out: r_ml};
        end
    end

    assign o_valid = r_ov;
    assign o_res   = r_res;

endmodule

`default_nettype wire

FILE: rtl/periodic_point_rotator.sv
// Top level of the periodic point rotator.
// Rotates one Q3.12 point per request by 2*pi*(frame mod period)/period and takes a new
// request every clock cycle while the output is not stalled. On its way to the output a
// request passes through 32 restoring-division stages that form frame mod period,
// ANGLE_BITS more that form the angle quotient, the four-entry queue, the CORDIC
// start stage, sixteen CORDIC stages and the trig rounding, multiply and saturation
// stages. A stalled output freezes the back end; the queue then fills, and the input
// is stalled once the last front stage cannot move into it. The period register
// resets to 60 and should be written only while no request is in flight.
`default_nettype none

module periodic_point_rotator #(
    parameter int ANGLE_BITS = ppr_pkg::DEF_ANGLE_BITS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire ppr_pkg::t_in_req                i_req,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output ppr_pkg::t_out_res                    o_res,
    input  wire logic                            i_cfg_we,
    input  wire logic [ppr_pkg::PERIOD_BITS-1:0] i_cfg_wdata
);
    import ppr_pkg::*;

    localparam int QW = ANGLE_BITS + $bits(t_point);

    logic [PERIOD_BITS-1:0] r_period;
    logic                   f_valid, q_full, q_valid, q_pop;
    logic [ANGLE_BITS-1:0]  f_angle, q_angle;
    t_point                 f_point, q_point;
    logic [QW-1:0]          q_out;

    // Period register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
        end else if (i_cfg_we) begin
            r_period <= i_cfg_wdata;
        end
    end

    ppr_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .i_period(r_period),
        .o_valid (f_valid),
        .i_full  (q_full),
        .o_angle (f_angle),
        .o_point (f_point)
    );

    ppr_queue #(.WIDTH(QW)) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (f_valid),
        .i_data ({f_angle, f_point}),
        .o_full (q_full),
        .o_valid(q_valid),
        .i_pop  (q_pop),
        .o_data (q_out)
    );

    assign q_angle = q_out[QW-1:$bits(t_point)];
    assign q_point = q_out[$bits(t_point)-1:0];

    ppr_back #(.ANGLE_BITS(ANGLE_BITS)) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(q_valid),
        .o_pop  (q_pop),
        .i_angle(q_angle),
        .i_point(q_point),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_res  (o_res)
    );

endmodule

`default_nettype wire

FILE: rtl/ppr_checker.sv
// Port-level checks of the periodic point rotator and their bind.
`default_nettype none

module ppr_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_valid,
    input wire logic                            o_stall,
    input wire logic                            o_valid,
    input wire logic                            i_stall,
    input wire ppr_pkg::t_out_res               o_res
);
    import ppr_pkg::*;

    logic [9:0] r_cnt;
    logic       acc_in, acc_out;

    assign acc_in  = i_valid && !o_stall;
    assign acc_out = o_valid && !i_stall;

    // Requests in flight.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= 10'(r_cnt + 10'(acc_in) - 10'(acc_out));
        end
    end

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_res))
        else $error("stalled result changed");

    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_cnt != '0)
        else $error("result without a request in flight");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == '0 |-> !o_stall)
        else $error("input stalled while empty");

endmodule

bind periodic_point_rotator ppr_checker u_ppr_checker (.*);

`default_nettype wire
